// ===== rtl/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants, types and helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int CFG_W          = 13;
    localparam int PIX_W          = 16;
    localparam int POS_W          = 12;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 3;
    localparam int ADDR_IDX_BIT   = 2;
    localparam int MIN_SIZE       = 3;
    localparam int MAX_HEIGHT     = 4096;
    localparam int CFG_FIELD_MAX  = 8191;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int WIN_EDGE       = 2;

    localparam logic [CFG_W-1:0] DEF_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] DEF_FRAME_HEIGHT = 13'd480;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic             has_result;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } center_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int hi);
        if (int'(v) < MIN_SIZE) begin
            return CFG_W'(MIN_SIZE);
        end
        if (int'(v) > hi) begin
            return CFG_W'(hi);
        end
        return v;
    endfunction

endpackage

// ===== rtl/mf3_ram.sv =====
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/mf3_pos.sv =====
// ----------------------------------------------------------------------------
// mf3_pos
// Row and column counters; line store address and window center per word.
// ----------------------------------------------------------------------------
module mf3_pos
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic                         frame_start,
    input  logic [CFG_W-1:0]             frame_width,
    input  logic [CFG_W-1:0]             frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0] addr,
    output center_t                      center
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0] col_reg, col_a, col_e, col_next;
    logic [POS_W-1:0] row_reg, row_a, row_e, row_next;
    logic [POS_W:0]   row_b, row_inc;
    logic [COL_W:0]   col_inc;
    logic             wrap_col;

    always_comb begin
        col_a    = frame_start ? '0 : col_reg;
        row_a    = frame_start ? '0 : row_reg;
        wrap_col = 32'(col_a) >= 32'(frame_width);
        col_e    = wrap_col ? '0 : col_a;
        row_b    = wrap_col ? {1'b0, row_a} + 1'b1 : {1'b0, row_a};
        row_e    = (32'(row_b) >= 32'(frame_height)) ? '0 : row_b[POS_W-1:0];
        col_inc  = {1'b0, col_e} + 1'b1;
        row_inc  = {1'b0, row_e} + 1'b1;
        if (32'(col_inc) >= 32'(frame_width)) begin
            col_next = '0;
            row_next = (32'(row_inc) >= 32'(frame_height)) ? '0 : row_inc[POS_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_e;
        end
        addr              = col_e;
        center.has_result = (32'(row_e) >= WIN_EDGE) && (32'(col_e) >= WIN_EDGE);
        center.row        = row_e - 1'b1;
        center.col        = POS_W'(32'(col_e) - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median
// Column sort, sorted window of two columns and three-stage median network.
// ----------------------------------------------------------------------------
module mf3_median
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  center_t               in_center,
    input  logic [PIXEL_BITS-1:0] top,
    input  logic [PIXEL_BITS-1:0] mid,
    input  logic [PIXEL_BITS-1:0] px,
    output logic                  out_valid,
    output center_t               out_center,
    output logic [PIXEL_BITS-1:0] out_median
);

    typedef logic [2:0][PIXEL_BITS-1:0] column_t;

    function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] med3(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b,
                                                   input logic [PIXEL_BITS-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    column_t               col_new, w0_reg, w1_reg;
    column_t               s2_c0_reg, s2_c1_reg, s2_c2_reg;
    logic                  s2_valid_reg, s3_valid_reg;
    center_t               s2_center_reg, s3_center_reg;
    logic [PIXEL_BITS-1:0] s3_lo_reg, s3_md_reg, s3_hi_reg;

    always_comb begin
        col_new[0] = min2(min2(top, mid), px);
        col_new[1] = med3(top, mid, px);
        col_new[2] = max2(max2(top, mid), px);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= in_valid && in_center.has_result;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (in_valid) begin
                w0_reg        <= w1_reg;
                w1_reg        <= col_new;
                s2_c0_reg     <= w0_reg;
                s2_c1_reg     <= w1_reg;
                s2_c2_reg     <= col_new;
                s2_center_reg <= in_center;
            end
            s3_lo_reg     <= max2(max2(s2_c0_reg[0], s2_c1_reg[0]), s2_c2_reg[0]);
            s3_md_reg     <= med3(s2_c0_reg[1], s2_c1_reg[1], s2_c2_reg[1]);
            s3_hi_reg     <= min2(min2(s2_c0_reg[2], s2_c1_reg[2]), s2_c2_reg[2]);
            s3_center_reg <= s2_center_reg;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_center = s3_center_reg;
    assign out_median = med3(s3_lo_reg, s3_md_reg, s3_hi_reg);

endmodule

// ===== rtl/median_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster-order grayscale pixel stream.
//
// Input words carry one pixel in s_tdata and the frame start flag in s_tuser;
// a set flag restarts the frame at row 0, column 0. Rows wrap after
// frame_width pixels and frames after frame_height rows.
// For every pixel at row >= 2 and column >= 2 one output word carries the
// median of the 3x3 neighborhood centered one row up and one column left,
// with that center's row and column. Border pixels give no output word.
// Throughput is one pixel per cycle while the receiver does not stall; each
// taken pixel passes the s1, median and output registers before its output word
// appears. The two lines above the current pixel live in one line store RAM,
// one entry per column, read and written back once per pixel, with forwarding
// when a frame restart revisits the column just written. When the receiver
// stalls the whole pipeline holds and s_tready drops. Reset clears counters and
// pipeline valids and sets the frame size to 640 x 480; the line store is not cleared.
// ----------------------------------------------------------------------------
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,   // pixel
    input  logic              s_tuser,   // frame_start
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // median_value, center_row, center_col
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_HI = (MAX_WIDTH < CFG_FIELD_MAX) ? MAX_WIDTH : CFG_FIELD_MAX;

    logic [CFG_W-1:0]        frame_width_reg, frame_height_reg;
    logic                    en, accept, cfg_write;
    logic [COL_W-1:0]        rd_addr, s1_addr_reg;
    center_t                 center, s1_center_reg, med_center;
    logic                    s1_valid_reg, s1_fwd_reg;
    logic [PIXEL_BITS-1:0]   s1_px_reg, s1_top, s1_mid, med_value;
    logic [2*PIXEL_BITS-1:0] rd_data, s1_word, s1_fwd_data_reg;
    logic                    med_valid;
    logic [PIX_W-1:0]        m_median_reg;
    logic [POS_W-1:0]        m_row_reg, m_col_reg;
    logic                    m_tvalid_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DEF_FRAME_WIDTH;
            frame_height_reg <= DEF_FRAME_HEIGHT;
        end else if (cfg_write) begin
            case (reg_idx_t'(paddr[ADDR_IDX_BIT]))
                REG_FRAME_WIDTH:  frame_width_reg  <= clamp_size(pwdata[CFG_W-1:0], WIDTH_HI);
                REG_FRAME_HEIGHT: frame_height_reg <= clamp_size(pwdata[CFG_W-1:0], MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[ADDR_IDX_BIT]))
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    mf3_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .frame_start  (s_tuser),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .addr         (rd_addr),
        .center       (center)
    );

    // low half: upper line, high half: middle line
    assign s1_word = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
    assign s1_top  = s1_word[PIXEL_BITS-1:0];
    assign s1_mid  = s1_word[2*PIXEL_BITS-1:PIXEL_BITS];

    mf3_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (en && s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata ({s1_px_reg, s1_mid}),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg     <= rd_addr;
            s1_center_reg   <= center;
            s1_px_reg       <= s_tdata[PIXEL_BITS-1:0];
            s1_fwd_reg      <= s1_valid_reg && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= {s1_px_reg, s1_mid};
        end
    end

    mf3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s1_valid_reg),
        .in_center  (s1_center_reg),
        .top        (s1_top),
        .mid        (s1_mid),
        .px         (s1_px_reg),
        .out_valid  (med_valid),
        .out_center (med_center),
        .out_median (med_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= med_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_median_reg <= PIX_W'(med_value);
            m_row_reg    <= med_center.row;
            m_col_reg    <= med_center.col;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg, m_median_reg};

endmodule
